>>> src/rics_pkg.sv
// Shared constants for the integer core step: datapath widths,
// opcode and function codes. No dependencies.
`timescale 1ns / 1ps

package rics_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned RIDX_W = 5;
  localparam int unsigned NREGS  = 32;

  typedef logic [5:0] opcode_t;
  typedef logic [5:0] funct_t;

  // Primary opcodes
  localparam opcode_t OP_SPECIAL = 6'b000000;
  localparam opcode_t OP_REGIMM  = 6'b000001;
  localparam opcode_t OP_BEQ     = 6'b000100;
  localparam opcode_t OP_BNE     = 6'b000101;
  localparam opcode_t OP_ADDI    = 6'b001000;
  localparam opcode_t OP_ADDIU   = 6'b001001;
  localparam opcode_t OP_SLTI    = 6'b001010;
  localparam opcode_t OP_ANDI    = 6'b001100;
  localparam opcode_t OP_ORI     = 6'b001101;
  localparam opcode_t OP_XORI    = 6'b001110;
  localparam opcode_t OP_LB      = 6'b100000;
  localparam opcode_t OP_LW      = 6'b100011;
  localparam opcode_t OP_SB      = 6'b101000;
  localparam opcode_t OP_SW      = 6'b101011;

  // SPECIAL function codes
  localparam funct_t FN_SLL  = 6'd0;
  localparam funct_t FN_SRL  = 6'd2;
  localparam funct_t FN_SRA  = 6'd3;
  localparam funct_t FN_ADD  = 6'd32;
  localparam funct_t FN_ADDU = 6'd33;
  localparam funct_t FN_SUB  = 6'd34;
  localparam funct_t FN_SUBU = 6'd35;
  localparam funct_t FN_AND  = 6'd36;
  localparam funct_t FN_OR   = 6'd37;
  localparam funct_t FN_XOR  = 6'd38;
  localparam funct_t FN_NOR  = 6'd39;
  localparam funct_t FN_SLT  = 6'd42;

  // REGIMM rt code for BLTZ
  localparam logic [RIDX_W-1:0] RT_BLTZ = 5'd0;

endpackage

>>> src/rics_in_if.sv
// Instruction channel: valid/ready handshake carrying one instruction word.
// Depends on rics_pkg for the word width.
`timescale 1ns / 1ps

interface rics_in_if;
  import rics_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

>>> src/rics_out_if.sv
// Result channel: valid/ready handshake carrying the retire record of one
// instruction. Depends on rics_pkg for widths.
`timescale 1ns / 1ps

interface rics_out_if;
  import rics_pkg::*;

  logic              valid;
  logic              ready;
  logic [XLEN-1:0]   pc_after;
  logic              reg_write;
  logic [RIDX_W-1:0] reg_dest;
  logic [XLEN-1:0]   reg_value;
  logic              overflow_flag;
  logic              misaligned_flag;
  logic              store_done;
  logic              branch_taken;
  logic              unknown_op;

  modport source (
    output valid, output pc_after, output reg_write, output reg_dest, output reg_value,
    output overflow_flag, output misaligned_flag, output store_done,
    output branch_taken, output unknown_op, input ready
  );
  modport sink (
    input valid, input pc_after, input reg_write, input reg_dest, input reg_value,
    input overflow_flag, input misaligned_flag, input store_done,
    input branch_taken, input unknown_op, output ready
  );
endinterface

>>> src/risc_integer_core_step.sv
// Integer core step: executes one instruction word per transaction against the pc,
// a 32-entry register file and a DATA_WORDS data memory. Throughput is one transaction
// per cycle absent stalls or back-pressure, through execute, index, read, writeback.
// A register operand produced by a load one or two transactions earlier holds the
// instruction in execute until the load data leaves the memory port.
// Reset (rst_n low, synchronous) zeroes the pc and register valid bits, then a clearing
// pass writes DATA_WORDS zero words, one per cycle, with in_chan.ready held low.
`timescale 1ns / 1ps

module risc_integer_core_step #(
  parameter int DATA_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  rics_in_if.sink           in_chan,
  rics_out_if.source        out_chan
);
  import rics_pkg::*;

  localparam int IW     = $clog2(DATA_WORDS);   // data memory index width
  localparam int SW     = IW + 2;               // width of the folded index sum
  localparam int TAB_N  = 256;                  // entries per 8-bit address chunk
  localparam int TAB_HI = 64;                   // entries for the top 6-bit chunk

  // Per-instruction record carried down the pipe
  typedef struct packed {
    logic [XLEN-1:0]   pc_after;
    logic              wr;
    logic [RIDX_W-1:0] dst;
    logic [XLEN-1:0]   val;
    logic [XLEN-1:0]   b;
    logic              ld;
    logic              lb;
    logic              st;
    logic              sb;
    logic [1:0]        lane;
    logic              ovf;
    logic              mis;
    logic              br;
    logic              unk;
  } op_t;

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when the one below is free or leaving
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_mv, s2_mv, s3_mv, s4_mv;
  logic s1_free, s2_free, s3_free, s4_free, out_free;
  logic s1_hold, hazard, in_acc;
  logic clr_busy_r;
  logic [IW-1:0] clr_idx_r;

  assign out_free = !out_v_r || out_chan.ready;
  assign s4_mv    = s4_v_r && out_free;
  assign s4_free  = !s4_v_r || out_free;
  assign s3_mv    = s3_v_r && s4_free;
  assign s3_free  = !s3_v_r || s4_free;
  assign s2_mv    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_mv    = s1_v_r && s2_free && !hazard;
  assign s1_free  = !s1_v_r || s1_mv;
  assign s1_hold  = s1_v_r && !s1_mv;

  // Hold off new work during the clearing pass
  assign in_chan.ready = s1_free && !clr_busy_r;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // ---------------------------------------------------------------------------
  // Stage 1 registers: instruction word and architectural pc
  // ---------------------------------------------------------------------------
  logic [XLEN-1:0] s1_instr_r;
  logic [XLEN-1:0] pc_r, pc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_acc) begin
      s1_instr_r <= in_chan.instr_word;
    end
  end

  opcode_t           op;
  logic [RIDX_W-1:0] rs, rt, rd, sh;
  funct_t            fn;
  logic [15:0]       imm;

  assign op  = s1_instr_r[31:26];
  assign rs  = s1_instr_r[25:21];
  assign rt  = s1_instr_r[20:16];
  assign rd  = s1_instr_r[15:11];
  assign sh  = s1_instr_r[10:6];
  assign fn  = s1_instr_r[5:0];
  assign imm = s1_instr_r[15:0];

  // ---------------------------------------------------------------------------
  // Register file: synchronous memory, two read ports, one write port.
  // While stage 1 holds, re-read its operands so the read data tracks commits.
  // ---------------------------------------------------------------------------
  logic [XLEN-1:0]   rf_mem [NREGS];
  logic [NREGS-1:0]  rf_vld_r;
  logic [RIDX_W-1:0] rf_ra [2];
  logic [XLEN-1:0]   rf_q_r [2];
  logic              rf_vq_r [2];
  logic              rf_we;
  logic [RIDX_W-1:0] rf_wa;
  logic [XLEN-1:0]   rf_wd;

  assign rf_ra[0] = s1_hold ? rs : in_chan.instr_word[25:21];
  assign rf_ra[1] = s1_hold ? rt : in_chan.instr_word[20:16];

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    for (int k = 0; k < 2; k++) begin
      rf_q_r[k] <= rf_mem[rf_ra[k]];
    end
  end

  // Never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      rf_vq_r[k] <= rf_vld_r[rf_ra[k]];
    end
  end

  // Last committed write: covers the commit that lands on the same edge as a read
  logic              lw_v_r;
  logic [RIDX_W-1:0] lw_dst_r;
  logic [XLEN-1:0]   lw_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (rf_we) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      lw_dst_r <= rf_wa;
      lw_val_r <= rf_wd;
    end
  end

  // ---------------------------------------------------------------------------
  // Operand forwarding. Youngest pending writer wins; a load still ahead of the
  // memory port cannot supply its value yet, so stall stage 1.
  // ---------------------------------------------------------------------------
  op_t             s2_r, s3_r, s4_r;
  logic [XLEN-1:0] s4_val;
  logic [RIDX_W-1:0] opnd_idx [2];
  logic [XLEN-1:0]   opnd [2];
  logic              opnd_wait [2];

  assign opnd_idx[0] = rs;
  assign opnd_idx[1] = rt;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      opnd[k]      = rf_vq_r[k] ? rf_q_r[k] : '0;
      opnd_wait[k] = 1'b0;
      if (lw_v_r && lw_dst_r == opnd_idx[k]) begin
        opnd[k] = lw_val_r;
      end
      if (s4_v_r && s4_r.wr && s4_r.dst == opnd_idx[k]) begin
        opnd[k] = s4_val;
      end
      if (s3_v_r && s3_r.wr && s3_r.dst == opnd_idx[k]) begin
        opnd[k]      = s3_r.val;
        opnd_wait[k] = s3_r.ld;
      end
      if (s2_v_r && s2_r.wr && s2_r.dst == opnd_idx[k]) begin
        opnd[k]      = s2_r.val;
        opnd_wait[k] = s2_r.ld;
      end
    end
  end

  assign hazard = s1_v_r && (opnd_wait[0] || opnd_wait[1]);

  // ---------------------------------------------------------------------------
  // Stage 1 execute: decode, ALU, address, branch resolution, next pc
  // ---------------------------------------------------------------------------
  op_t             ex_op;
  logic [XLEN-1:0] a, b, si, zi, seq, addr, sum_ab, dif_ab;
  logic            wr_raw;

  assign a      = opnd[0];
  assign b      = opnd[1];
  assign si     = {{16{imm[15]}}, imm};
  assign zi     = {16'h0000, imm};
  assign seq    = pc_r + XLEN'(4);
  assign addr   = a + si;
  assign sum_ab = a + b;
  assign dif_ab = a - b;

  always_comb begin
    ex_op      = '0;
    ex_op.b    = b;
    ex_op.lane = addr[1:0];
    wr_raw     = 1'b0;
    ex_op.dst  = rt;
    unique case (op)
      OP_SPECIAL: begin
        ex_op.dst = rd;
        wr_raw    = 1'b1;
        unique case (fn)
          FN_ADD: begin
            ex_op.val = sum_ab;
            ex_op.ovf = (a[31] == b[31]) && (sum_ab[31] != a[31]);
          end
          FN_ADDU: ex_op.val = sum_ab;
          FN_SUB: begin
            ex_op.val = dif_ab;
            ex_op.ovf = (a[31] != b[31]) && (dif_ab[31] != a[31]);
          end
          FN_SUBU: ex_op.val = dif_ab;
          FN_SLT:  ex_op.val = XLEN'($signed(a) < $signed(b));
          FN_AND:  ex_op.val = a & b;
          FN_OR:   ex_op.val = a | b;
          FN_XOR:  ex_op.val = a ^ b;
          FN_NOR:  ex_op.val = ~(a | b);
          FN_SLL:  ex_op.val = b << sh;
          FN_SRL:  ex_op.val = b >> sh;
          FN_SRA:  ex_op.val = $unsigned($signed(b) >>> sh);
          default: begin
            wr_raw    = 1'b0;
            ex_op.unk = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        ex_op.val = addr;
        ex_op.ovf = (a[31] == si[31]) && (addr[31] != a[31]);
        wr_raw    = 1'b1;
      end
      OP_ADDIU: begin
        ex_op.val = addr;
        wr_raw    = 1'b1;
      end
      OP_SLTI: begin
        ex_op.val = XLEN'($signed(a) < $signed(si));
        wr_raw    = 1'b1;
      end
      OP_ANDI: begin
        ex_op.val = a & zi;
        wr_raw    = 1'b1;
      end
      OP_ORI: begin
        ex_op.val = a | zi;
        wr_raw    = 1'b1;
      end
      OP_XORI: begin
        ex_op.val = a ^ zi;
        wr_raw    = 1'b1;
      end
      OP_LW: begin
        ex_op.ld  = 1'b1;
        ex_op.mis = (addr[1:0] != 2'b00);
        wr_raw    = 1'b1;
      end
      OP_LB: begin
        ex_op.ld = 1'b1;
        ex_op.lb = 1'b1;
        wr_raw   = 1'b1;
      end
      OP_SW: begin
        ex_op.st  = 1'b1;
        ex_op.mis = (addr[1:0] != 2'b00);
      end
      OP_SB: begin
        ex_op.st = 1'b1;
        ex_op.sb = 1'b1;
      end
      OP_BEQ: ex_op.br = (a == b);
      OP_BNE: ex_op.br = (a != b);
      OP_REGIMM: begin
        if (rt == RT_BLTZ) begin
          ex_op.br = a[31];
        end else begin
          ex_op.unk = 1'b1;
        end
      end
      default: ex_op.unk = 1'b1;
    endcase
    // Writes to register zero are dropped
    ex_op.wr       = wr_raw && (ex_op.dst != '0);
    pc_nxt         = ex_op.br ? seq + {si[XLEN-3:0], 2'b00} : seq;
    ex_op.pc_after = pc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (s1_mv) begin
      pc_r <= pc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fold the word address modulo DATA_WORDS. Each chunk of the word address
  // (8 bits, top one 6) looks up its weight modulo DATA_WORDS in a constant table.
  // ---------------------------------------------------------------------------
  logic [IW-1:0] tab0 [TAB_N];
  logic [IW-1:0] tab1 [TAB_N];
  logic [IW-1:0] tab2 [TAB_N];
  logic [IW-1:0] tab3 [TAB_HI];

  for (genvar g = 0; g < TAB_N; g++) begin : g_mod_tab
    localparam int T0 = g % DATA_WORDS;
    localparam int T1 = (g * (2 ** 8)) % DATA_WORDS;
    localparam int T2 = (g * (2 ** 16)) % DATA_WORDS;
    assign tab0[g] = IW'(T0);
    assign tab1[g] = IW'(T1);
    assign tab2[g] = IW'(T2);
    if (g < TAB_HI) begin : g_hi
      localparam int T3 = (g * (2 ** 24)) % DATA_WORDS;
      assign tab3[g] = IW'(T3);
    end
  end

  logic [XLEN-1:0] s2_addr_r;
  logic [SW-1:0]   s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_r      <= ex_op;
      s2_addr_r <= addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reduce the folded sum below DATA_WORDS and issue the memory read
  // ---------------------------------------------------------------------------
  logic [SW-1:0] red1, red2;
  logic [IW-1:0] s3_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_mv) begin
      s3_r     <= s2_r;
      s3_sum_r <= SW'(tab0[s2_addr_r[9:2]]) + SW'(tab1[s2_addr_r[17:10]])
                + SW'(tab2[s2_addr_r[25:18]]) + SW'(tab3[s2_addr_r[31:26]]);
    end
  end

  // Sum stays below 4*DATA_WORDS: two conditional subtracts finish the job
  assign red1   = (s3_sum_r >= SW'(2 * DATA_WORDS)) ? s3_sum_r - SW'(2 * DATA_WORDS)
                                                    : s3_sum_r;
  assign red2   = (red1 >= SW'(DATA_WORDS)) ? red1 - SW'(DATA_WORDS) : red1;
  assign s3_idx = red2[IW-1:0];

  // ---------------------------------------------------------------------------
  // Data memory: one write port (clearing pass or store commit), one read port
  // ---------------------------------------------------------------------------
  logic [XLEN-1:0] dmem [DATA_WORDS];
  logic [XLEN-1:0] dmem_q_r;
  logic            dm_we;
  logic [IW-1:0]   dm_wa;
  logic [XLEN-1:0] dm_wd;
  logic [IW-1:0]   s4_idx_r;
  logic [XLEN-1:0] s4_stw;

  assign dm_we = clr_busy_r || (s4_mv && s4_r.st);
  assign dm_wa = clr_busy_r ? clr_idx_r : s4_idx_r;
  assign dm_wd = clr_busy_r ? '0 : s4_stw;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    if (s3_mv) begin
      dmem_q_r <= dmem[s3_idx];
    end
  end

  // Clearing pass after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + IW'(1);
      if (clr_idx_r == IW'(DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: load data, byte merge, commit to register file and data memory.
  // A store committing on the edge of our read gets forwarded here.
  // ---------------------------------------------------------------------------
  logic            s4_fhit_r;
  logic [XLEN-1:0] s4_fdat_r;
  logic [XLEN-1:0] s4_word, s4_ldv;
  logic [7:0]      s4_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_free) begin
      s4_v_r <= s3_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_mv) begin
      s4_r      <= s3_r;
      s4_idx_r  <= s3_idx;
      s4_fhit_r <= s4_mv && s4_r.st && (s4_idx_r == s3_idx);
      s4_fdat_r <= s4_stw;
    end
  end

  assign s4_word = s4_fhit_r ? s4_fdat_r : dmem_q_r;

  // Big-endian lanes: byte offset 0 is the top byte
  always_comb begin
    s4_stw = s4_r.b;
    case (s4_r.lane)
      2'd0: begin
        s4_byte = s4_word[31:24];
        if (s4_r.sb) s4_stw = {s4_r.b[7:0], s4_word[23:0]};
      end
      2'd1: begin
        s4_byte = s4_word[23:16];
        if (s4_r.sb) s4_stw = {s4_word[31:24], s4_r.b[7:0], s4_word[15:0]};
      end
      2'd2: begin
        s4_byte = s4_word[15:8];
        if (s4_r.sb) s4_stw = {s4_word[31:16], s4_r.b[7:0], s4_word[7:0]};
      end
      default: begin
        s4_byte = s4_word[7:0];
        if (s4_r.sb) s4_stw = {s4_word[31:8], s4_r.b[7:0]};
      end
    endcase
  end

  assign s4_ldv = s4_r.lb ? {{24{s4_byte[7]}}, s4_byte} : s4_word;
  assign s4_val = s4_r.ld ? s4_ldv : s4_r.val;

  assign rf_we = s4_mv && s4_r.wr;
  assign rf_wa = s4_r.dst;
  assign rf_wd = s4_val;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s4_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_mv) begin
      out_chan.pc_after        <= s4_r.pc_after;
      out_chan.reg_write       <= s4_r.wr;
      out_chan.reg_dest        <= s4_r.wr ? s4_r.dst : '0;
      out_chan.reg_value       <= s4_r.wr ? s4_val : '0;
      out_chan.overflow_flag   <= s4_r.ovf;
      out_chan.misaligned_flag <= s4_r.mis;
      out_chan.store_done      <= s4_r.st;
      out_chan.branch_taken    <= s4_r.br;
      out_chan.unknown_op      <= s4_r.unk;
    end
  end

  assign out_chan.valid = out_v_r;

`ifndef SYNTHESIS
  // A load-use stall keeps the waiting instruction in execute unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    hazard |=> s1_v_r && $stable(s1_instr_r))
    else $error("stalled instruction left execute");

  // Register zero is never committed
  assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> rf_wa != '0)
    else $error("write to register zero");

  // The clearing pass runs with an empty pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(s1_v_r || s2_v_r || s3_v_r || s4_v_r || out_v_r))
    else $error("work in flight during clearing pass");

  // Pc only advances when an instruction leaves execute
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_mv |=> $stable(pc_r))
    else $error("pc moved without a retiring instruction");
`endif

endmodule
